// ===== rtl/dmas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmas_pkg
// Shared types, codes and constants of the DNA motif affinity scanner:
// beat layouts, request and configuration codes, and the fixed-point
// constants of the bound-probability unit.
// ----------------------------------------------------------------------------
package dmas_pkg;

    // Default sizing of the top level
    localparam int DEF_MAX_MOTIF_LEN = 32;
    localparam int DEF_POSITION_BITS = 20;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int WPOS_W    = 5;
    localparam int WBASE_W   = 2;
    localparam int WEIGHT_W  = 16;
    localparam int LEN_CFG_W = 6;
    localparam int LNR0_W    = 16;
    localparam int SUM_W     = 36;
    localparam int START_W   = 20;
    localparam int SCORE_W   = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CHAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTIF_LEN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LN_R0     = 1'd1;

    // Legal sequence characters
    localparam logic [CHAR_W-1:0] CH_A_UC = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C_UC = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G_UC = 8'h47;
    localparam logic [CHAR_W-1:0] CH_T_UC = 8'h54;
    localparam logic [CHAR_W-1:0] CH_A_LC = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_LC = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_LC = 8'h74;

    // Input beat
    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic [CHAR_W-1:0]          char_code;
        logic [WPOS_W-1:0]          weight_pos;
        logic [WBASE_W-1:0]         weight_base;
        logic signed [WEIGHT_W-1:0] weight_value;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [SUM_W-1:0]   total_affinity;
        logic [START_W-1:0] best_start;
        logic [SCORE_W-1:0] best_score;
        logic               best_found;
    } t_out_item;

    // What a pipeline slot carries to the accumulator
    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_SCORE,
        TAG_END
    } t_tag;

    // Bound-probability arithmetic
    localparam int EXP_Q          = 24;
    localparam int E_W            = EXP_Q + 1;
    localparam int PROD_W         = E_W + EXP_Q;
    localparam int ARG_W          = 14;
    localparam int A_W            = 13;
    localparam int SAT_ARG        = 4096;
    localparam int EXP_INT_STEPS  = 16;
    localparam int PROB_W         = 16;
    localparam int QUOT_W         = PROB_W + 1;
    localparam int D_W            = E_W + 1;
    localparam int NUM_W          = EXP_Q + PROB_W + 1;
    localparam int DIV_W          = NUM_W + 1;
    localparam int PROB_LAT       = 2 + EXP_INT_STEPS + 1 + QUOT_W;

    localparam logic [E_W-1:0]    ONE_Q24  = E_W'(1) << EXP_Q;
    localparam logic [EXP_Q-1:0]  EXP_M1   = 24'd6171993;
    localparam logic [NUM_W-1:0]  NUM_ONE  = NUM_W'(1) << (EXP_Q + PROB_W);
    localparam logic [QUOT_W-1:0] PROB_ONE = QUOT_W'(1) << PROB_W;
    localparam int                ROUND_HALF = 32768;

    localparam logic [EXP_Q-1:0] FRAC [8] = '{
        24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
        24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896
    };

    // exp(-f) in Q1.24 for every fraction f of 8 bits, folded bit by bit
    typedef logic [E_W-1:0] t_exp_tab [256];

    function automatic t_exp_tab f_exp_frac_tab();
        t_exp_tab    tab;
        logic [63:0] e;
        for (int i = 0; i < 256; i++) begin
            e = 64'(ONE_Q24);
            for (int k = 0; k < 8; k++) begin
                if (i[k]) begin
                    e = (e * 64'(FRAC[k])) >> EXP_Q;
                end
            end
            tab[i] = e[E_W-1:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_FRAC_TAB = f_exp_frac_tab();

endpackage

// ===== rtl/dna_motif_affinity_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_motif_affinity_scanner_unit
// Streams DNA characters past one Q8.8 energy matrix, scores every window of
// legal bases on both strands and reports sum and best window on an end beat.
// ----------------------------------------------------------------------------
// The unit takes one input beat per clock unless the input stalls. A result
// beat leaves once its end beat has passed the energy adder tree, the exp(-1)
// folding chain of 16 multiply stages and the 17-stage quotient pipeline. The
// input stalls only while an end beat at the tail of the pipeline waits for a
// full, stalled output register. The weight store is a bank of flip-flops, one
// row of four weights per motif position, with no clearing pass; a weight must
// be loaded before a window uses it. The configuration port reports ready only
// when no scoring beat is in flight.
// ----------------------------------------------------------------------------
module dna_motif_affinity_scanner_unit
    import dmas_pkg::*;
#(
    parameter int MAX_MOTIF_LEN = DEF_MAX_MOTIF_LEN,
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    // result beats
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int LEN_W    = $clog2(MAX_MOTIF_LEN + 1);
    localparam int SLOT_W   = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int LV       = $clog2(MAX_MOTIF_LEN);
    localparam int NLEAF    = 1 << LV;
    localparam int ENERGY_W = WEIGHT_W + LV + 1;
    localparam int DEPTH    = LV + PROB_LAT + 3;
    localparam int FLIGHT_W = $clog2(DEPTH + 2);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [SUM_W-1:0]         SUM_MAX = '1;

    logic adv;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_CFG_W-1:0]     r_motif_len;
    logic signed [LNR0_W-1:0] r_ln_r0;
    logic [LEN_W-1:0]         eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif_len <= LEN_CFG_W'(1);
            r_ln_r0     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MOTIF_LEN: r_motif_len <= i_cfg_data[LEN_CFG_W-1:0];
                CFG_LN_R0:     r_ln_r0     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the motif length into 1..MAX_MOTIF_LEN
    always_comb begin
        if (r_motif_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_motif_len) > MAX_MOTIF_LEN) begin
            eff_len = LEN_W'(MAX_MOTIF_LEN);
        end else begin
            eff_len = LEN_W'(r_motif_len);
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic     r_in_valid;
    t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Front: decode, window, run length, weight store
    // ------------------------------------------------------------------
    logic                       is_load;
    logic                       is_char;
    logic                       is_end;
    logic                       legal;
    logic [1:0]                 base;
    logic [1:0]                 r_window [MAX_MOTIF_LEN];
    logic [1:0]                 n_window [MAX_MOTIF_LEN];
    logic [LEN_W-1:0]           r_legal_run;
    logic [LEN_W-1:0]           n_legal_run;
    logic [POSITION_BITS-1:0]   r_pos;
    logic [POSITION_BITS-1:0]   len_m1;
    logic [POSITION_BITS-1:0]   win_start;
    logic                       score_now;
    logic signed [WEIGHT_W-1:0] r_weight [MAX_MOTIF_LEN][4];

    // Split the beat by request type
    always_comb begin
        is_load = 1'b0;
        is_char = 1'b0;
        is_end  = 1'b0;
        unique case (r_in.req_type)
            REQ_LOAD: is_load = r_in_valid;
            REQ_CHAR: is_char = r_in_valid;
            REQ_END:  is_end  = r_in_valid;
            default: ;
        endcase
    end

    // Map the character to a base code
    always_comb begin
        legal = 1'b1;
        base  = 2'd0;
        case (r_in.char_code) inside
            CH_A_UC, CH_A_LC: base = 2'd0;
            CH_C_UC, CH_C_LC: base = 2'd1;
            CH_G_UC, CH_G_LC: base = 2'd2;
            CH_T_UC, CH_T_LC: base = 2'd3;
            default:          legal = 1'b0;
        endcase
    end

    // Shift a legal base in; newest base sits in slot 0
    always_comb begin
        n_window = r_window;
        if (legal) begin
            for (int j = MAX_MOTIF_LEN - 1; j > 0; j--) begin
                n_window[j] = r_window[j-1];
            end
            n_window[0] = base;
        end
    end

    always_comb begin
        if (!legal) begin
            n_legal_run = '0;
        end else if (r_legal_run < LEN_W'(MAX_MOTIF_LEN)) begin
            n_legal_run = r_legal_run + LEN_W'(1);
        end else begin
            n_legal_run = r_legal_run;
        end
    end

    assign score_now = is_char && legal && (n_legal_run >= eff_len);
    assign len_m1    = POSITION_BITS'(eff_len - LEN_W'(1));
    assign win_start = (r_pos >= len_m1) ? (r_pos - len_m1) : '0;

    // Advance sequence state; an end beat clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_legal_run <= '0;
            r_pos       <= '0;
            for (int j = 0; j < MAX_MOTIF_LEN; j++) begin
                r_window[j] <= 2'd0;
            end
        end else if (adv) begin
            if (is_char) begin
                r_legal_run <= n_legal_run;
                r_window    <= n_window;
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + POSITION_BITS'(1);
                end
            end else if (is_end) begin
                r_legal_run <= '0;
                r_pos       <= '0;
                for (int j = 0; j < MAX_MOTIF_LEN; j++) begin
                    r_window[j] <= 2'd0;
                end
            end
        end
    end

    // Write a loaded weight; positions beyond the matrix are dropped
    always_ff @(posedge i_clk) begin
        if (adv && is_load && (32'(r_in.weight_pos) < MAX_MOTIF_LEN)) begin
            r_weight[SLOT_W'(r_in.weight_pos)][r_in.weight_base] <= r_in.weight_value;
        end
    end

    // ------------------------------------------------------------------
    // Per-position weight terms, forward and reverse complement
    // ------------------------------------------------------------------
    logic signed [ENERGY_W-1:0] r_node_fw [1:2*NLEAF-1];
    logic signed [ENERGY_W-1:0] r_node_rc [1:2*NLEAF-1];

    for (genvar m = 0; m < NLEAF; m++) begin : g_lane
        if (m < MAX_MOTIF_LEN) begin : g_used
            logic [LEN_W-1:0] slot;
            logic             in_use;
            logic [1:0]       fw_base;
            assign slot    = eff_len - LEN_W'(1) - LEN_W'(m);
            assign in_use  = LEN_W'(m) < eff_len;
            assign fw_base = n_window[slot[SLOT_W-1:0]];
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_node_fw[NLEAF+m] <= in_use ? ENERGY_W'(r_weight[m][fw_base]) : '0;
                    r_node_rc[NLEAF+m] <= in_use ? ENERGY_W'(r_weight[m][~n_window[m]]) : '0;
                end
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_node_fw[NLEAF+m] <= '0;
                    r_node_rc[NLEAF+m] <= '0;
                end
            end
        end
    end

    // Registered adder tree, one level per stage; root is node 1
    for (genvar n = 1; n < NLEAF; n++) begin : g_tree
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_node_fw[n] <= r_node_fw[2*n] + r_node_fw[2*n+1];
                r_node_rc[n] <= r_node_rc[2*n] + r_node_rc[2*n+1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Bound probabilities for both strands
    // ------------------------------------------------------------------
    logic [PROB_W-1:0] pf;
    logic [PROB_W-1:0] pc;

    dmas_prob_unit #(
        .ENERGY_W (ENERGY_W)
    ) u_prob_fw (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_energy (r_node_fw[1]),
        .i_ln_r0  (r_ln_r0),
        .o_prob   (pf)
    );

    dmas_prob_unit #(
        .ENERGY_W (ENERGY_W)
    ) u_prob_rc (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_energy (r_node_rc[1]),
        .i_ln_r0  (r_ln_r0),
        .o_prob   (pc)
    );

    // ------------------------------------------------------------------
    // Window score Pf + (1 - Pf) * Pc
    // ------------------------------------------------------------------
    logic [2*QUOT_W-1:0]  r_sc_prod;
    logic [PROB_W-1:0]    r_sc_pf;
    logic [PROB_W+1:0]    s_full;
    logic [SCORE_W-1:0]   r_score;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sc_prod <= (2*QUOT_W)'(PROB_ONE - QUOT_W'(pf)) * (2*QUOT_W)'(pc);
            r_sc_pf   <= pf;
        end
    end

    assign s_full = (PROB_W+2)'(r_sc_pf)
                  + (PROB_W+2)'((r_sc_prod + (2*QUOT_W)'(ROUND_HALF)) >> PROB_W);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_score <= s_full[PROB_W+1:PROB_W] != 2'b00 ? '1 : s_full[SCORE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Beat tags and window starts travel beside the datapath
    // ------------------------------------------------------------------
    t_tag                     r_tag  [DEPTH];
    logic [POSITION_BITS-1:0] r_mpos [DEPTH];
    t_tag                     tag_in;

    always_comb begin
        if (score_now) begin
            tag_in = TAG_SCORE;
        end else if (is_end) begin
            tag_in = TAG_END;
        end else begin
            tag_in = TAG_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_tag[k] <= TAG_NONE;
            end
        end else if (adv) begin
            r_tag[0] <= tag_in;
            for (int k = 1; k < DEPTH; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mpos[0] <= win_start;
            for (int k = 1; k < DEPTH; k++) begin
                r_mpos[k] <= r_mpos[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Flow control: hold everything only when an end beat cannot leave
    // ------------------------------------------------------------------
    logic                r_out_valid;
    logic [FLIGHT_W-1:0] r_flight;
    logic                flight_inc;
    logic                flight_dec;

    assign adv        = !((r_tag[DEPTH-1] == TAG_END) && r_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    // Count scoring beats in flight; configuration waits for none
    assign flight_inc = adv && score_now;
    assign flight_dec = adv && (r_tag[DEPTH-1] == TAG_SCORE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flight <= '0;
        end else if (flight_inc != flight_dec) begin
            r_flight <= flight_inc ? r_flight + FLIGHT_W'(1) : r_flight - FLIGHT_W'(1);
        end
    end

    assign o_cfg_ready = !r_in_valid && (r_flight == '0);

    // ------------------------------------------------------------------
    // Accumulate scores, track first best window, emit on end
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W:0]           sum_next;
    logic [SCORE_W-1:0]       r_best_value;
    logic [POSITION_BITS-1:0] r_best_pos;
    logic                     r_best_valid;
    t_out_item                r_out;

    assign sum_next = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_score);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_sum        <= '0;
            r_best_value <= '0;
            r_best_pos   <= '0;
            r_best_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                case (r_tag[DEPTH-1])
                    TAG_SCORE: begin
                        r_sum <= sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
                        if (!r_best_valid || (r_score > r_best_value)) begin
                            r_best_valid <= 1'b1;
                            r_best_value <= r_score;
                            r_best_pos   <= r_mpos[DEPTH-1];
                        end
                    end
                    TAG_END: begin
                        r_out_valid  <= 1'b1;
                        r_sum        <= '0;
                        r_best_value <= '0;
                        r_best_pos   <= '0;
                        r_best_valid <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (adv && (r_tag[DEPTH-1] == TAG_END)) begin
            r_out.total_affinity <= r_sum;
            r_out.best_start     <= r_best_valid ? START_W'(r_best_pos) : '0;
            r_out.best_score     <= r_best_valid ? r_best_value : '0;
            r_out.best_found     <= r_best_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_tag[DEPTH-1] == TAG_END)) |=> o_out_valid)
        else $error("end beat left the tail without loading a result");

    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_tag[DEPTH-1] != TAG_SCORE))
        else $error("configuration ready while a window is still being scored");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.best_found) |->
        ((o_out_data.best_score == '0) && (o_out_data.best_start == '0)))
        else $error("result without a scored window carries a best window");

    a_sum_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_tag[DEPTH-1] != TAG_END)) |=> (r_sum >= $past(r_sum)))
        else $error("affinity sum fell without an end beat");

endmodule

// ===== rtl/dmas_prob_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmas_prob_unit
// Pipelined bound probability P = sigmoid(ln_r0 - E) in Q0.16. Saturates the
// argument, looks up exp of the fraction, folds in exp(-1) once per stage for
// the integer part, then divides one quotient bit per stage.
// ----------------------------------------------------------------------------
module dmas_prob_unit
    import dmas_pkg::*;
#(
    parameter int ENERGY_W = 22
) (
    input  logic                       i_clk,
    input  logic                       i_adv,
    input  logic signed [ENERGY_W-1:0] i_energy,
    input  logic signed [LNR0_W-1:0]   i_ln_r0,
    output logic [PROB_W-1:0]          o_prob
);

    localparam int XW = ENERGY_W + 1;

    // Saturated argument
    logic signed [XW-1:0]    x_full;
    logic signed [ARG_W-1:0] x_sat;
    logic signed [ARG_W-1:0] r_x;

    assign x_full = XW'(i_ln_r0) - XW'(i_energy);

    always_comb begin
        if (x_full > $signed(XW'(SAT_ARG))) begin
            x_sat = ARG_W'(SAT_ARG);
        end else if (x_full < -$signed(XW'(SAT_ARG))) begin
            x_sat = -$signed(ARG_W'(SAT_ARG));
        end else begin
            x_sat = ARG_W'(x_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x <= x_sat;
        end
    end

    // Magnitude, fraction lookup; slot 0 of the exp chain
    logic [A_W-1:0] a_abs;
    logic [E_W-1:0] r_me   [0:EXP_INT_STEPS];
    logic [4:0]     r_mn   [0:EXP_INT_STEPS];
    logic           r_mneg [0:EXP_INT_STEPS];

    assign a_abs = A_W'(r_x[ARG_W-1] ? -r_x : r_x);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_me[0]   <= EXP_FRAC_TAB[a_abs[7:0]];
            r_mn[0]   <= a_abs[A_W-1:8];
            r_mneg[0] <= r_x[ARG_W-1];
        end
    end

    // One exp(-1) factor per stage while integer units remain
    for (genvar i = 0; i < EXP_INT_STEPS; i++) begin : g_exp
        logic [PROD_W-1:0] prod;
        assign prod = PROD_W'(r_me[i]) * PROD_W'(EXP_M1);
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_me[i+1]   <= (r_mn[i] > 5'(i)) ? prod[PROD_W-1:EXP_Q] : r_me[i];
                r_mn[i+1]   <= r_mn[i];
                r_mneg[i+1] <= r_mneg[i];
            end
        end
    end

    // Form numerator and divisor
    logic [D_W-1:0]   den;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] r_rem [0:QUOT_W];
    logic [D_W-1:0]   r_den [0:QUOT_W];
    logic [QUOT_W-1:0] r_q  [0:QUOT_W];

    assign den = D_W'(r_me[EXP_INT_STEPS]) + D_W'(ONE_Q24);

    always_comb begin
        if (r_mneg[EXP_INT_STEPS]) begin
            num = (NUM_W'(r_me[EXP_INT_STEPS]) << PROB_W) + NUM_W'(den >> 1);
        end else begin
            num = NUM_ONE + NUM_W'(den >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= num;
            r_den[0] <= den;
            r_q[0]   <= '0;
        end
    end

    // Restoring division, most significant quotient bit first
    for (genvar j = 0; j < QUOT_W; j++) begin : g_div
        logic [DIV_W-1:0] sub_den;
        logic             ge;
        assign sub_den = DIV_W'(r_den[j]) << (QUOT_W - 1 - j);
        assign ge      = DIV_W'(r_rem[j]) >= sub_den;
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[j+1] <= ge ? NUM_W'(DIV_W'(r_rem[j]) - sub_den) : r_rem[j];
                r_den[j+1] <= r_den[j];
                r_q[j+1]   <= {r_q[j][QUOT_W-2:0], ge};
            end
        end
    end

    // Clip the one case that reaches 1.0
    assign o_prob = r_q[QUOT_W][QUOT_W-1] ? '1 : r_q[QUOT_W][PROB_W-1:0];

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DNA motif affinity scanner. A short directed
// list of beats, with hand-worked reports where they are obvious, is
// followed by random scans over several motif-length and offset settings.
// The random scans run under several idle and stall mixes, and one phase
// holds the report port off long enough to back the unit up. Every report
// beat is checked field by field against a hand-worked report or a bit-exact scan model.
// ----------------------------------------------------------------------------
module testbench;
    import dmas_pkg::*;

    localparam int MOTIF_MAX      = 32;
    localparam longint unsigned POS_SAT = (64'd1 << 20) - 64'd1;
    localparam longint unsigned SUM_SAT = (64'd1 << 36) - 64'd1;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int ARG_LIMIT      = 4096;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int N_PHASES       = 12;
    localparam int PHASE_BEATS    = 93;
    localparam int PRESSURE_PHASE = 6;

    // exp(-2^k / 256) and exp(-1) in Q0.24
    localparam longint unsigned EXP_NEG_BIT [8] = '{
        64'd16711808, 64'd16646655, 64'd16517109, 64'd16261035,
        64'd15760736, 64'd14805841, 64'd13066109, 64'd10175896
    };
    localparam longint unsigned EXP_NEG_ONE = 64'd6171993;

    localparam logic [CHAR_W-1:0] LEGAL_CH [8] = '{
        CH_A_UC, CH_C_UC, CH_G_UC, CH_T_UC, CH_A_LC, CH_C_LC, CH_G_LC, CH_T_LC
    };

    // Per-phase register settings; phases 4 and 9 draw their own
    localparam int PH_LEN [N_PHASES] = '{1, 32, 0, 63, 20, 33, 8, 2, 16, 20, 5, 12};
    localparam int PH_R0  [N_PHASES] = '{
        0, 32767, -32768, 1024, 0, -512, 768, 2048, -1, 0, 4096, -256
    };

    // Zero weights and zero offset: one half on each strand, so 1/2 + 1/4
    localparam t_out_item HALF_REPORT = '{
        total_affinity: 36'd49152, best_start: 20'd0, best_score: 16'd49152, best_found: 1'b1
    };

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item report;
    } t_dir_row;

    // DUT ports
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Scan model state
    logic signed [WEIGHT_W-1:0] mdl_weight [MOTIF_MAX*4];
    logic [1:0]                 mdl_window [MOTIF_MAX];
    int                         mdl_run;
    longint unsigned            mdl_pos;
    longint unsigned            mdl_sum;
    longint unsigned            mdl_best_pos;
    longint unsigned            mdl_best_score;
    bit                         mdl_best_ok;
    int unsigned                mdl_len;
    logic signed [LNR0_W-1:0]   mdl_r0;
    t_out_item                  pending_reports [$];

    // Bench bookkeeping
    int        n_beats       = 0;
    int        n_reports     = 0;
    int        n_errors      = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        hold_requests = 0;
    int        hold_served   = 0;
    int        hold_left     = 0;
    int        cycle_count   = 0;
    t_out_item want;
    t_dir_row  dir_rows [$];

    dna_motif_affinity_scanner_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------
    function automatic int base_of(input logic [CHAR_W-1:0] c);
        case (c)
            CH_A_UC, CH_A_LC: return 0;
            CH_C_UC, CH_C_LC: return 1;
            CH_G_UC, CH_G_LC: return 2;
            CH_T_UC, CH_T_LC: return 3;
            default: return -1;
        endcase
    endfunction

    // Clamp the programmed length to what the unit can use
    function automatic int eff_len();
        if (mdl_len == 0) return 1;
        if (mdl_len > MOTIF_MAX) return MOTIF_MAX;
        return int'(mdl_len);
    endfunction

    // Bound probability sigmoid(x) in Q0.16, x in Q8.8
    function automatic longint unsigned occupancy_q16(input longint x);
        longint unsigned mag, e, d, p;
        if (x > ARG_LIMIT) x = ARG_LIMIT;
        if (x < -ARG_LIMIT) x = -ARG_LIMIT;
        mag = (x < 0) ? -x : x;
        e = 64'd1 << 24;
        for (int k = 0; k < 8; k++) begin
            if (mag[k]) e = (e * EXP_NEG_BIT[k]) >> 24;
        end
        for (longint i = 0; i < longint'(mag >> 8); i++) begin
            e = (e * EXP_NEG_ONE) >> 24;
        end
        d = (64'd1 << 24) + e;
        if (x >= 0) begin
            p = ((64'd1 << 40) + (d >> 1)) / d;
            if (p > 64'd65535) p = 64'd65535;
        end else begin
            p = ((e << 16) + (d >> 1)) / d;
        end
        return p;
    endfunction

    function automatic void clear_scan();
        foreach (mdl_window[j]) mdl_window[j] = 2'd0;
        mdl_run        = 0;
        mdl_pos        = 0;
        mdl_sum        = 0;
        mdl_best_pos   = 0;
        mdl_best_score = 0;
        mdl_best_ok    = 1'b0;
    endfunction

    // Shift one character in and score the window it completes
    function automatic void score_char(input logic [CHAR_W-1:0] c);
        int              b, len, sm;
        longint unsigned here, pf, pc, s;
        longint          ef, ec;
        b    = base_of(c);
        len  = eff_len();
        here = mdl_pos;
        if (mdl_pos < POS_SAT) mdl_pos++;
        if (b < 0) begin
            mdl_run = 0;
            return;
        end
        for (int j = MOTIF_MAX - 1; j > 0; j--) mdl_window[j] = mdl_window[j-1];
        mdl_window[0] = 2'(b);
        if (mdl_run < MOTIF_MAX) mdl_run++;
        if (mdl_run < len) return;
        ef = 0;
        ec = 0;
        for (int m = 0; m < len; m++) begin
            sm = int'(mdl_window[len-1-m]);
            ef += longint'(mdl_weight[m*4 + sm]);
            ec += longint'(mdl_weight[(len-1-m)*4 + 3 - sm]);
        end
        pf = occupancy_q16(longint'(mdl_r0) - ef);
        pc = occupancy_q16(longint'(mdl_r0) - ec);
        s  = pf + (((64'd65536 - pf) * pc + 64'd32768) >> 16);
        if (s > 64'd65535) s = 64'd65535;
        mdl_sum += s;
        if (mdl_sum > SUM_SAT) mdl_sum = SUM_SAT;
        // strictly higher only: the first of equal windows stays
        if (!mdl_best_ok || s > mdl_best_score) begin
            mdl_best_ok    = 1'b1;
            mdl_best_score = s;
            mdl_best_pos   = (here >= longint'(len - 1)) ? here - longint'(len - 1) : 0;
        end
    endfunction

    // Advance the model by one accepted beat; queue the report of an end beat
    function automatic void track_beat(input t_in_item it, input bit typed,
                                       input t_out_item typed_res);
        t_out_item rep;
        case (it.req_type)
            REQ_LOAD: mdl_weight[{it.weight_pos, it.weight_base}] = it.weight_value;
            REQ_CHAR: score_char(it.char_code);
            REQ_END: begin
                rep.total_affinity = mdl_sum[SUM_W-1:0];
                rep.best_start     = mdl_best_ok ? mdl_best_pos[START_W-1:0] : '0;
                rep.best_score     = mdl_best_ok ? mdl_best_score[SCORE_W-1:0] : '0;
                rep.best_found     = mdl_best_ok;
                pending_reports.push_back(typed ? typed_res : rep);
                clear_scan();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic t_in_item beat(input logic [REQ_W-1:0] req,
                                      input logic [CHAR_W-1:0] ch,
                                      input logic [WPOS_W-1:0] pos,
                                      input logic [WBASE_W-1:0] base,
                                      input logic [WEIGHT_W-1:0] val);
        t_in_item it;
        it.req_type     = req;
        it.char_code    = ch;
        it.weight_pos   = pos;
        it.weight_base  = base;
        it.weight_value = val;
        return it;
    endfunction

    function automatic t_dir_row dir_row(input t_in_item stim, input bit typed = 1'b0,
                                         input t_out_item report = '0);
        t_dir_row r;
        r.stim   = stim;
        r.typed  = typed;
        r.report = report;
        return r;
    endfunction

    function automatic t_in_item noise_beat();
        t_in_item it;
        it.req_type     = 2'($urandom_range(3));
        it.char_code    = 8'($urandom);
        it.weight_pos   = 5'($urandom);
        it.weight_base  = 2'($urandom);
        it.weight_value = 16'($urandom);
        return it;
    endfunction

    // Mostly small weights so that scores stay away from the rails
    function automatic logic [WEIGHT_W-1:0] rand_weight();
        int r, v;
        r = int'($urandom_range(99));
        if (r < 70) v = int'($urandom_range(192)) - 96;
        else if (r < 90) v = int'($urandom_range(2048)) - 1024;
        else v = int'($urandom_range(65535));
        return v[WEIGHT_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] illegal_char();
        logic [CHAR_W-1:0] c;
        do c = 8'($urandom); while (base_of(c) >= 0);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one beat after a random idle gap and hold it until taken
    task automatic offer(input t_in_item it, input bit typed = 1'b0,
                         input t_out_item typed_res = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_beat(it, typed, typed_res);
        if (it.req_type != REQ_SPARE) n_beats++;
    endtask

    // Write both registers back to back
    task automatic set_config(input logic [CFG_DATA_W-1:0] len_data,
                              input logic [CFG_DATA_W-1:0] r0_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MOTIF_LEN;
        i_cfg_data  <= len_data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_LN_R0;
        i_cfg_data  <= r0_data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mdl_len = int'(len_data[LEN_CFG_W-1:0]);
        mdl_r0  = r0_data;
    endtask

    // Drop valid, wait for every report, then let the pipe run empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One scan: characters with a little noise, closed by an end beat;
    // a broken scan is mostly noise and may leave the end beat out
    task automatic send_stretch(input bit broken);
        int       n, r;
        t_in_item it;
        n = ($urandom_range(9) == 0) ? int'($urandom_range(eff_len()))
                                     : eff_len() + int'($urandom_range(24));
        for (int k = 0; k < n; k++) begin
            it = noise_beat();
            r  = int'($urandom_range(99));
            if (r < (broken ? 35 : 3)) begin
                it.req_type  = REQ_CHAR;
                it.char_code = illegal_char();
            end else if (r < (broken ? 50 : 6)) begin
                it.req_type     = REQ_LOAD;
                it.weight_value = rand_weight();
            end else if (r < (broken ? 60 : 8)) begin
                it.req_type = REQ_SPARE;
            end else begin
                it.req_type  = REQ_CHAR;
                it.char_code = LEGAL_CH[$urandom_range(7)];
            end
            offer(it);
        end
        if (!broken || $urandom_range(1) == 1) begin
            it = noise_beat();
            it.req_type = REQ_END;
            offer(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Report port: random stall, or a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check each report beat against the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                n_errors++;
                $display("%0t ns: report with nothing pending: sum %0d start %0d score %0d found %0b",
                         $time, o_out_data.total_affinity, o_out_data.best_start,
                         o_out_data.best_score, o_out_data.best_found);
            end else begin
                want = pending_reports.pop_front();
                n_reports++;
                if (o_out_data.total_affinity !== want.total_affinity ||
                    o_out_data.best_start     !== want.best_start     ||
                    o_out_data.best_score     !== want.best_score     ||
                    o_out_data.best_found     !== want.best_found) begin
                    n_errors++;
                    $display("%0t ns: report mismatch: expected sum %0d start %0d score %0d found %0b",
                             $time, want.total_affinity, want.best_start, want.best_score,
                             want.best_found);
                    $display("%0t ns:                  actual   sum %0d start %0d score %0d found %0b",
                             $time, o_out_data.total_affinity, o_out_data.best_start,
                             o_out_data.best_score, o_out_data.best_found);
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                    ph, phase_start, len_val;
        logic [CFG_DATA_W-1:0] len_data, r0_data;
        t_in_item              it;

        clear_scan();
        mdl_len = 1;
        mdl_r0  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at reset settings: length 1, zero offset
        dir_rows.push_back(dir_row(beat(REQ_END, 8'h00, 5'd0, 2'd0, 16'h0000), 1'b1, '0));
        dir_rows.push_back(dir_row(beat(REQ_LOAD, 8'h00, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_LOAD, 8'h00, 5'd0, 2'd1, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_LOAD, 8'h00, 5'd0, 2'd2, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_LOAD, 8'h00, 5'd0, 2'd3, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, CH_A_UC, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_END, 8'h00, 5'd0, 2'd0, 16'h0000), 1'b1, HALF_REPORT));
        // illegal characters only: nothing scored
        dir_rows.push_back(dir_row(beat(REQ_CHAR, 8'h00, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, 8'hFF, 5'd31, 2'd3, 16'hFFFF)));
        dir_rows.push_back(dir_row(beat(REQ_END, 8'h00, 5'd0, 2'd0, 16'h0000), 1'b1, '0));
        // weight extremes, top motif position
        dir_rows.push_back(dir_row(beat(REQ_LOAD, 8'h00, 5'd0, 2'd0, 16'h8000)));
        dir_rows.push_back(dir_row(beat(REQ_LOAD, 8'h00, 5'd0, 2'd3, 16'h7FFF)));
        dir_rows.push_back(dir_row(beat(REQ_LOAD, 8'h00, 5'd31, 2'd0, 16'h8000)));
        dir_rows.push_back(dir_row(beat(REQ_LOAD, 8'h00, 5'd31, 2'd3, 16'h7FFF)));
        // spare request type must leave the weights alone
        dir_rows.push_back(dir_row(beat(REQ_SPARE, CH_A_UC, 5'd0, 2'd0, 16'h1234)));
        // both cases, an illegal base mid-run, equal scores on C and c
        dir_rows.push_back(dir_row(beat(REQ_CHAR, CH_A_LC, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, CH_C_LC, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, 8'h4E, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, CH_T_LC, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, CH_G_UC, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, CH_T_UC, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, CH_C_UC, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_CHAR, CH_G_LC, 5'd0, 2'd0, 16'h0000)));
        dir_rows.push_back(dir_row(beat(REQ_END, 8'h00, 5'd0, 2'd0, 16'h0000)));

        foreach (dir_rows[i]) offer(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].report);

        // Fill the whole matrix before any longer motif reads it
        for (int p = 0; p < MOTIF_MAX * 4; p++) begin
            it = noise_beat();
            it.req_type     = REQ_LOAD;
            it.weight_pos   = 5'(p >> 2);
            it.weight_base  = 2'(p);
            it.weight_value = rand_weight();
            offer(it);
        end

        // Random phases, one register setting and one idle mix each
        for (ph = 0; ph < N_PHASES; ph++) begin
            settle();
            len_val = (ph % 5 == 4) ? int'($urandom_range(32, 1)) : PH_LEN[ph];
            len_data = CFG_DATA_W'(len_val);
            if ($urandom_range(1) == 1) len_data[CFG_DATA_W-1:LEN_CFG_W] = 10'($urandom);
            r0_data = (ph % 5 == 4) ? 16'($urandom) : 16'(PH_R0[ph]);
            set_config(len_data, r0_data);
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 58;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 58;
                end
                default: begin
                    send_idle_pct = 18;
                    stall_pct     = 18;
                end
            endcase
            // hold the report port off while beats keep coming
            if (ph == PRESSURE_PHASE) begin
                send_idle_pct = 0;
                hold_requests++;
            end
            phase_start = n_beats;
            while (n_beats - phase_start < PHASE_BEATS) send_stretch($urandom_range(6) == 0);
        end
        settle();

        $display("summary: %0d beats over %0d register settings, %0d reports checked, %0d mismatches",
                 n_beats, N_PHASES + 1, n_reports, n_errors);
        $display("summary: lengths 0..63 with clamping, offset extremes, idle and stall mixes, long hold-off");
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dmas_pkg.sv
rtl/dmas_prob_unit.sv
rtl/dna_motif_affinity_scanner_unit.sv
dv/testbench.sv
